[hdl/perfect_power_exponent_macros.svh]
// Assertion macros shared by the perfect power exponent RTL.
`ifndef PERFECT_POWER_EXPONENT_MACROS_SVH
`define PERFECT_POWER_EXPONENT_MACROS_SVH

`ifndef ASSERT_OFF
`define PPE_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");
`define PPE_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");
`else
`define PPE_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons)
`define PPE_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons)
`endif

`endif

[hdl/ppe_pkg.sv]
`timescale 1ns / 1ps
package ppe_pkg;

  localparam int POWER_W = 6;

  typedef logic [3:0] step_t;

  // program addresses
  localparam step_t S_IDLE  = 4'd0;
  localparam step_t S_DINIT = 4'd1;
  localparam step_t S_DSTEP = 4'd2;
  localparam step_t S_TEST  = 4'd3;
  localparam step_t S_GCD   = 4'd4;
  localparam step_t S_BOUND = 4'd5;
  localparam step_t S_NEXTD = 4'd6;
  localparam step_t S_SUCC  = 4'd7;
  localparam step_t S_TAIL  = 4'd8;
  localparam step_t S_TLOAD = 4'd9;
  localparam step_t S_TSUB  = 4'd10;
  localparam step_t S_TESTP = 4'd11;
  localparam step_t S_PDEC  = 4'd12;
  localparam step_t S_EMIT  = 4'd13;

  typedef enum logic [3:0] {
    OP_NOP, OP_LOAD, OP_DINIT, OP_DSTEP, OP_GCD, OP_DINC,
    OP_MAGQ, OP_TAIL, OP_TLOAD, OP_TSUB, OP_PDEC, OP_EMIT
  } op_t;

  typedef enum logic [3:0] {
    C_NEVER, C_ALWAYS, C_NO_START, C_MAG_ZERO, C_DIV_BUSY,
    C_REM_ZERO, C_E_NZ, C_Q_LT_D, C_T_GE_P, C_FOUND
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } uword_t;

  // control store: jump to target when cond holds, else fall through
  function automatic uword_t ucode(step_t addr);
    uword_t w;
    unique case (addr)
      S_IDLE:  w = '{OP_LOAD,  C_NO_START, S_IDLE};
      S_DINIT: w = '{OP_DINIT, C_MAG_ZERO, S_TAIL};
      S_DSTEP: w = '{OP_DSTEP, C_DIV_BUSY, S_DSTEP};
      S_TEST:  w = '{OP_NOP,   C_REM_ZERO, S_SUCC};
      S_GCD:   w = '{OP_GCD,   C_E_NZ,     S_GCD};
      S_BOUND: w = '{OP_NOP,   C_Q_LT_D,   S_TAIL};
      S_NEXTD: w = '{OP_DINC,  C_ALWAYS,   S_DINIT};
      S_SUCC:  w = '{OP_MAGQ,  C_ALWAYS,   S_DINIT};
      S_TAIL:  w = '{OP_TAIL,  C_NEVER,    S_IDLE};
      S_TLOAD: w = '{OP_TLOAD, C_NEVER,    S_IDLE};
      S_TSUB:  w = '{OP_TSUB,  C_T_GE_P,   S_TSUB};
      S_TESTP: w = '{OP_NOP,   C_FOUND,    S_EMIT};
      S_PDEC:  w = '{OP_PDEC,  C_ALWAYS,   S_TLOAD};
      S_EMIT:  w = '{OP_EMIT,  C_ALWAYS,   S_IDLE};
      default: w = '{OP_NOP,   C_ALWAYS,   S_IDLE};
    endcase
    return w;
  endfunction

endpackage

[hdl/perfect_power_exponent.sv]
// Run time: one trial division per candidate divisor up to sqrt(|value|), plus one per prime
//   factor found; the bit-serial remainder unit dominates it, and the worst case is a prime
//   close to 2^31.
// Throughput: one request at a time; busy stays high from acceptance until done pulses.
// Reset: rst (synchronous, active high) returns the sequencer to idle and clears done.
// done is a one-cycle strobe; the receiver cannot stall it.
`timescale 1ns / 1ps
`include "perfect_power_exponent_macros.svh"

module perfect_power_exponent #(
  parameter int MAX_POWER   = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [VALUE_WIDTH-1:0]    value,
  output logic                             done,
  output logic [ppe_pkg::POWER_W-1:0]      power
);
  import ppe_pkg::*;

  localparam int VW   = VALUE_WIDTH;
  localparam int EW   = $clog2(VALUE_WIDTH);      // exponents stay below VALUE_WIDTH
  localparam int CNTW = $clog2(VALUE_WIDTH);      // division bit counter
  localparam int PW   = $clog2(MAX_POWER + 1);    // candidate exponent p
  localparam int CW   = (EW > PW) ? EW : PW;      // common compare width for t and p

  // ---------------------------------------------------------------- sequencer
  step_t  pc, pc_next;
  uword_t uw;
  logic   take;

  // ---------------------------------------------------------------- datapath
  logic            neg;
  logic [VW-1:0]   mag;      // remaining cofactor
  logic [VW-1:0]   d;        // trial divisor
  logic [VW:0]     rem;      // partial remainder, one guard bit
  logic [VW-1:0]   quo;      // dividend shifting out, quotient shifting in
  logic [CNTW-1:0] cnt;
  logic [EW-1:0]   e;        // exponent of current divisor, then gcd operand
  logic [EW-1:0]   g;        // running gcd of exponents
  logic [EW-1:0]   t;        // g mod p by repeated subtraction
  logic [PW-1:0]   p;        // candidate answer, counts down

  logic [VW-1:0]   value_u;
  logic [VW:0]     rem_sh;
  logic [VW:0]     d_ext;
  logic            div_ge;
  logic [CW-1:0]   t_ext, p_ext;

  assign uw      = ucode(pc);
  assign value_u = unsigned'(value);
  assign rem_sh  = {rem[VW-1:0], quo[VW-1]};
  assign d_ext   = {1'b0, d};
  assign div_ge  = (rem_sh >= d_ext);
  assign t_ext   = CW'(t);
  assign p_ext   = CW'(p);

  // jump conditions
  always_comb begin
    unique case (uw.cond)
      C_NEVER:    take = 1'b0;
      C_ALWAYS:   take = 1'b1;
      C_NO_START: take = !start;
      C_MAG_ZERO: take = (mag == '0);
      C_DIV_BUSY: take = (cnt != CNTW'(VW - 1));
      C_REM_ZERO: take = (rem == '0);
      C_E_NZ:     take = (e != '0);
      C_Q_LT_D:   take = (quo < d);
      C_T_GE_P:   take = (t_ext >= p_ext);
      C_FOUND:    take = (t == '0) && (!neg || p[0]);
      default:    take = 1'b0;
    endcase
  end

  assign pc_next = take ? uw.target : step_t'(pc + 1'b1);
  assign busy    = (pc != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      pc   <= S_IDLE;
      done <= 1'b0;
    end else begin
      pc   <= pc_next;
      done <= (uw.op == OP_EMIT);
    end
  end

  // datapath operations, one per control word
  always_ff @(posedge clk) begin
    unique case (uw.op)
      OP_NOP: begin
      end
      OP_LOAD: begin
        if (start) begin
          neg <= value_u[VW-1];
          mag <= value_u[VW-1] ? (~value_u + 1'b1) : value_u;  // -2^(VW-1) wraps exactly
          d   <= VW'(2);
          e   <= '0;
          g   <= '0;
        end
      end
      OP_DINIT: begin
        rem <= '0;
        quo <= mag;
        cnt <= '0;
      end
      OP_DSTEP: begin
        // restoring division, one quotient bit per cycle
        rem <= div_ge ? (rem_sh - d_ext) : rem_sh;
        quo <= {quo[VW-2:0], div_ge};
        cnt <= cnt + 1'b1;
      end
      OP_GCD: begin
        // subtractive Euclid; ends with e cleared and the gcd in g
        if (e != '0) begin
          if (g >= e) begin
            g <= g - e;
          end else begin
            g <= e;
            e <= g;
          end
        end
      end
      OP_DINC: begin
        d <= d + 1'b1;
      end
      OP_MAGQ: begin
        mag <= quo;
        e   <= e + 1'b1;
      end
      OP_TAIL: begin
        // a leftover prime above sqrt has exponent one
        if (mag > VW'(1)) g <= EW'(1);
        p <= PW'(MAX_POWER);
      end
      OP_TLOAD: begin
        t <= g;
      end
      OP_TSUB: begin
        if (t_ext >= p_ext) t <= EW'(t_ext - p_ext);
      end
      OP_PDEC: begin
        p <= p - 1'b1;
      end
      OP_EMIT: begin
        power <= POWER_W'(p);
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------- checks
  `PPE_ASSERT_IMP(a_done_idle, clk, rst, done, !busy)
  `PPE_ASSERT_NXT(a_accept_busy, clk, rst, start && !busy, busy)
  `PPE_ASSERT_IMP(a_div_nonzero, clk, rst, pc == S_DSTEP, d >= VW'(2))
  `PPE_ASSERT_NXT(a_done_pulse, clk, rst, done, !done)

endmodule

[sim/perfect_power_exponent_test.sv]
`timescale 1ns / 1ps

// Testbench for perfect_power_exponent.
// A directed table comes first, then 80 random requests. Most random
// requests are perfect powers of small bases or products of small primes, so
// that trial division ends quickly. Each result is checked against its typed-in
// answer or against a local model of the exponent search.
module perfect_power_exponent_test;
  import ppe_pkg::*;

  localparam int          TOP_POWER    = 32;
  localparam int          RANDOM_COUNT = 80;
  // Overall limit on simulated cycles; the run reports FAILURE once it is passed.
  localparam longint      CYCLE_LIMIT  = 4_000_000;
  localparam int          SETTLE       = 64;

  typedef struct {
    logic signed [31:0]  value;
    logic [POWER_W-1:0]  power;
    bit                  known;   // power typed in; otherwise predicted
  } row_t;

  typedef struct {
    logic signed [31:0]  value;
    logic [POWER_W-1:0]  power;
  } pending_t;

  // Directed requests. Extremes and the zero/one magnitudes carry their answer.
  localparam int ROWS = 23;
  row_t directed [ROWS] = '{
    '{32'sd0,            6'd32, 1'b1},  // zero: every p divides
    '{32'sd1,            6'd32, 1'b1},  // one: no prime factors
    '{-32'sd1,           6'd31, 1'b1},  // minus one: largest odd p
    '{32'sh8000_0000,    6'd31, 1'b1},  // most negative: -(2^31)
    '{32'sh4000_0000,    6'd30, 1'b1},  // 2^30
    '{-32'sd1073741824,  6'd15, 1'b1},  // -(2^30): odd part of 30
    '{32'sd2,            6'd0,  1'b0},
    '{-32'sd2,           6'd0,  1'b0},
    '{32'sd4,            6'd0,  1'b0},
    '{-32'sd8,           6'd0,  1'b0},
    '{32'sd65536,        6'd0,  1'b0},
    '{-32'sd65536,       6'd0,  1'b0},  // even exponent only, negative
    '{32'sd36,           6'd0,  1'b0},
    '{32'sd7776,         6'd0,  1'b0},  // 6^5
    '{-32'sd7776,        6'd0,  1'b0},
    '{32'sd1162261467,   6'd0,  1'b0},  // 3^19
    '{-32'sd1162261467,  6'd0,  1'b0},
    '{32'sd12,           6'd0,  1'b0},  // mixed exponents
    '{32'sd88529281,     6'd0,  1'b0},  // 97^4
    '{32'sd10007,        6'd0,  1'b0},  // prime left over after the search
    '{32'sd2985984,      6'd0,  1'b0},  // 2^12 * 3^6
    '{-32'sd2985984,     6'd0,  1'b0},
    '{32'sh7FFF_0000,    6'd0,  1'b0}   // high bits set, positive
  };

  localparam int SMALL_PRIMES [25] = '{
    2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41,
    43, 47, 53, 59, 61, 67, 71, 73, 79, 83, 89, 97
  };

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic signed [31:0]  value = '0;
  logic                busy;
  logic                done;
  logic [POWER_W-1:0]  power;

  pending_t power_due [$];
  int       errors = 0;
  longint   cycles = 0;

  perfect_power_exponent dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .value (value),
    .done  (done),
    .power (power)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic longint unsigned gcd_of(longint unsigned a, longint unsigned b);
    longint unsigned t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  // Largest p <= TOP_POWER that divides every prime exponent. Negative values
  // need an odd p.
  function automatic logic [POWER_W-1:0] predict_power(logic signed [31:0] v);
    logic [31:0]      u;
    longint unsigned  mag, d, e, g;
    bit               neg;
    logic [POWER_W-1:0] best;
    neg  = v[31];
    u    = neg ? (~v + 32'd1) : v;   // 2^31 stays exact as unsigned
    mag  = 64'(u);
    g    = 0;
    best = 1;
    for (d = 2; d * d <= mag; d++) begin
      e = 0;
      while (mag % d == 0) begin
        mag /= d;
        e++;
      end
      if (e != 0) g = gcd_of(g, e);
    end
    if (mag > 1) g = gcd_of(g, 1);
    for (int p = TOP_POWER; p >= 1; p--) begin
      if (g % p == 0 && !(neg && p % 2 == 0)) begin
        best = p[POWER_W-1:0];
        break;
      end
    end
    return best;
  endfunction

  // Most draws are b^k or smooth products, so the search never runs long.
  // The rest are small magnitudes, which gives noise at a low cost.
  function automatic logic signed [31:0] draw_value();
    int               kind, b, kmax, k, pr;
    bit               neg;
    longint unsigned  lim, m;
    logic [31:0]      w;
    kind = $urandom_range(0, 99);
    neg  = 1'($urandom_range(0, 1));
    lim  = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    if (kind < 60) begin
      b = $urandom_range(2, 60);
      m = 64'(b);
      kmax = 1;
      while (m * b <= lim) begin
        m *= b;
        kmax++;
      end
      k = (kmax >= 2) ? $urandom_range(2, kmax) : 1;
      m = 1;
      repeat (k) m *= b;
    end else if (kind < 85) begin
      m = 1;
      repeat ($urandom_range(1, 30)) begin
        pr = SMALL_PRIMES[$urandom_range(0, 24)];
        if (m * pr <= lim) m *= pr;
      end
    end else begin
      m = 64'($urandom_range(0, 16383));
    end
    w = m[31:0];
    return neg ? (~w + 32'd1) : w;
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    $display("mismatch @%0d: %s", cycles, msg);
  endtask

  // One request: idle for gap cycles, then hold start until the block takes it.
  // With gap 0, start stays high from the previous request.
  task automatic send_request(input logic signed [31:0] v, input logic [POWER_W-1:0] p,
                              input bit known, input int gap);
    pending_t entry;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    value <= v;
    do @(posedge clk); while (busy);
    entry.value = v;
    entry.power = known ? p : predict_power(v);
    power_due = {power_due, entry};
  endtask

  // done strobes for one cycle, and the block cannot be held off.
  always @(posedge clk) begin
    pending_t head;
    if (!rst && done) begin
      if (power_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result power=%0d", power));
      end else begin
        head = power_due.pop_front();
        if (power !== head.power)
          report_mismatch($sformatf("value=%0d power=%0d want %0d",
                                    head.value, power, head.power));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    bit dense;
    int gap;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i])
      send_request(directed[i].value, directed[i].power, directed[i].known,
                   $urandom_range(0, 11));

    // Let every directed result arrive before the random part starts.
    start <= 1'b0;
    while (power_due.size() != 0) @(posedge clk);

    dense = 1'b0;
    for (int n = 0; n < RANDOM_COUNT; n++) begin
      // Back-to-back stretches now and then, otherwise random gaps.
      if (n % 16 == 0) dense = ($urandom_range(0, 2) == 0);
      gap = dense ? 0 : $urandom_range(0, 11);
      send_request(draw_value(), '0, 1'b0, gap);
    end
    start <= 1'b0;

    while (power_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/ppe_pkg.sv
hdl/perfect_power_exponent.sv
sim/perfect_power_exponent_test.sv
